// ===== sv/apm_pkg.sv =====
package apm_pkg;

    // Channel and field geometry
    localparam int CHANNELS   = 8;
    localparam int CH_W       = 3;
    localparam int SAMPLE_W   = 24;
    localparam int LEVEL_W    = 24;
    localparam int SQR_W      = 2 * LEVEL_W;
    localparam int SUM_W      = 59;
    localparam int CNT_W      = 13;
    localparam int HOLD_W     = 23;
    localparam int MAXHOLD_W  = 22;
    localparam int ACT_W      = 4;
    localparam int DECAY_W    = 16;
    localparam int ROOT_REM_W = 26;

    // Block length limit and reset values of the settings
    localparam int MAX_BLOCK  = 4096;
    localparam logic [CNT_W-1:0]     MAX_BLOCK_CNT   = CNT_W'(MAX_BLOCK);
    localparam logic [MAXHOLD_W-1:0] MAX_HOLD_RESET  = MAXHOLD_W'(48000);
    localparam logic [ACT_W-1:0]     ACTIVE_CH_RESET = ACT_W'(2);

    // RMS decay of 0.9 in Q0.16
    localparam logic [DECAY_W-1:0] DECAY_Q16 = DECAY_W'(58982);

    // Serial unit step counts
    localparam int STEP_W     = 6;
    localparam int SQR_STEPS  = LEVEL_W;
    localparam int DIV_STEPS  = SUM_W;
    localparam int ROOT_STEPS = LEVEL_W;
    localparam logic [STEP_W-1:0] SQR_LAST  = STEP_W'(SQR_STEPS - 1);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);
    localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_STEPS - 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = MAXHOLD_W;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HOLD  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CH = CFG_IDX_W'(1);

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SQR,
        S_ACC,
        S_DIV,
        S_ROOT,
        S_UPD
    } t_state;

endpackage

// ===== sv/audio_peak_rms_level_meter.sv =====
// Multichannel peak-hold / RMS level meter. Each input transaction carries one
// signed Q1.23 sample for one channel; samples of channels at or above the
// active channel count are taken at once and dropped. A metered sample is
// squared by a bit-serial shift-add multiplier and added to the channel's
// sum; o_in_ready stays low at least until the sum is updated. A sample
// flagged block_end then runs a bit-serial restoring divider for the block
// mean and a two-bits-per-step square root, and a final step updates the
// meters and loads the report; that step waits while an earlier report is
// still held in the output register. One report leaves per block. Settings
// may be written only while the meter is idle; they never disturb the meter
// state.
module audio_peak_rms_level_meter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [apm_pkg::CH_W-1:0]            i_channel,
    input  logic signed [apm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_block_end,
    // report channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [apm_pkg::CH_W-1:0]            o_report_channel,
    output logic [apm_pkg::LEVEL_W-1:0]         o_rms_level,
    output logic [apm_pkg::LEVEL_W-1:0]         o_held_peak,
    output logic [apm_pkg::LEVEL_W-1:0]         o_overall_peak,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [apm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [apm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import apm_pkg::*;

    // Settings
    logic [MAXHOLD_W-1:0] r_max_hold;
    logic [ACT_W-1:0]     r_active_ch;

    // Per-channel state
    logic [LEVEL_W-1:0] r_block_peak [CHANNELS];
    logic [SUM_W-1:0]   r_square_sum [CHANNELS];
    logic [CNT_W-1:0]   r_block_cnt  [CHANNELS];
    logic [LEVEL_W-1:0] r_rms_meter  [CHANNELS];
    logic [LEVEL_W-1:0] r_peak_meter [CHANNELS];
    logic [LEVEL_W-1:0] r_overall    [CHANNELS];
    logic [HOLD_W-1:0]  r_hold_left  [CHANNELS];

    // Sequencer
    t_state r_state;
    t_state n_state;
    logic [STEP_W-1:0] r_cnt;

    // Working registers of the current transaction
    logic [CH_W-1:0]       r_ch;
    logic [LEVEL_W-1:0]    r_mag;
    logic                  r_last;
    logic [SQR_W-1:0]      r_mul_acc;
    logic [LEVEL_W-1:0]    r_cur;
    logic [CNT_W-1:0]      r_n;
    logic [LEVEL_W-1:0]    r_decay;
    logic [SUM_W-1:0]      r_div_num;
    logic [CNT_W-1:0]      r_div_rem;
    logic [SQR_W-1:0]      r_root_src;
    logic [ROOT_REM_W-1:0] r_root_rem;
    logic [LEVEL_W-1:0]    r_root;

    // Output register
    logic                  r_out_valid;
    logic [CH_W-1:0]       r_out_ch;
    logic [LEVEL_W-1:0]    r_out_rms;
    logic [LEVEL_W-1:0]    r_out_peak;
    logic [LEVEL_W-1:0]    r_out_overall;

    logic w_accept;
    logic w_active;
    logic w_out_free;
    logic [LEVEL_W-1:0] w_mag;

    // Magnitude of the incoming sample; the most negative code maps to 2^23
    assign w_mag    = i_sample[SAMPLE_W-1] ? ($unsigned(~i_sample) + LEVEL_W'(1))
                                           : $unsigned(i_sample);
    assign w_active = {1'b0, i_channel} < r_active_ch;
    assign w_accept = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Serial square: shift-add, one multiplier bit per cycle
    logic [LEVEL_W:0] w_mul_sum;
    assign w_mul_sum = {1'b0, r_mul_acc[SQR_W-1:LEVEL_W]}
                     + {1'b0, (r_mul_acc[0] ? r_mag : '0)};

    // Accumulator update at the end of the square
    logic               w_cnt_ok;
    logic [SUM_W-1:0]   w_sum_new;
    logic [CNT_W-1:0]   w_cnt_new;
    logic [LEVEL_W-1:0] w_peak_new;
    assign w_cnt_ok   = r_block_cnt[r_ch] < MAX_BLOCK_CNT;
    assign w_sum_new  = w_cnt_ok ? (r_square_sum[r_ch] + {{(SUM_W-SQR_W){1'b0}}, r_mul_acc})
                                 : r_square_sum[r_ch];
    assign w_cnt_new  = w_cnt_ok ? (r_block_cnt[r_ch] + CNT_W'(1)) : r_block_cnt[r_ch];
    assign w_peak_new = (r_mag > r_block_peak[r_ch]) ? r_mag : r_block_peak[r_ch];

    // RMS decay product, registered before use
    logic [LEVEL_W+DECAY_W-1:0] w_decay_prod;
    assign w_decay_prod = {{DECAY_W{1'b0}}, r_rms_meter[r_ch]}
                        * {{LEVEL_W{1'b0}}, DECAY_Q16};

    // Restoring divider step: one quotient bit per cycle
    logic [CNT_W:0]   w_div_trial;
    logic             w_div_ge;
    logic [CNT_W:0]   w_div_diff;
    logic [SUM_W-1:0] w_div_num_nx;
    assign w_div_trial  = {r_div_rem, r_div_num[SUM_W-1]};
    assign w_div_ge     = w_div_trial >= {1'b0, r_n};
    assign w_div_diff   = w_div_trial - {1'b0, r_n};
    assign w_div_num_nx = {r_div_num[SUM_W-2:0], w_div_ge};

    // Square root step: two radicand bits per cycle, one root bit
    logic [ROOT_REM_W+1:0] w_root_t;
    logic [ROOT_REM_W+1:0] w_root_trial;
    logic                  w_root_ge;
    logic [ROOT_REM_W+1:0] w_root_diff;
    assign w_root_t     = {r_root_rem, r_root_src[SQR_W-1:SQR_W-2]};
    assign w_root_trial = {{(ROOT_REM_W-LEVEL_W){1'b0}}, r_root, 2'b01};
    assign w_root_ge    = w_root_t >= w_root_trial;
    assign w_root_diff  = w_root_t - w_root_trial;

    // Meter update at block end
    logic signed [HOLD_W:0] w_hold_diff;
    logic                   w_peak_take;
    logic [LEVEL_W-1:0]     w_rms_upd;
    logic [LEVEL_W-1:0]     w_peak_upd;
    logic [LEVEL_W-1:0]     w_overall_upd;
    logic [HOLD_W-1:0]      w_hold_upd;
    always_comb begin
        w_hold_diff   = $signed({r_hold_left[r_ch][HOLD_W-1], r_hold_left[r_ch]})
                      - $signed({{(HOLD_W+1-CNT_W){1'b0}}, r_n});
        w_peak_take   = r_cur >= r_peak_meter[r_ch];
        w_rms_upd     = (r_root >= r_rms_meter[r_ch]) ? r_root : r_decay;
        w_overall_upd = (r_cur > r_overall[r_ch]) ? r_cur : r_overall[r_ch];
        if (w_peak_take) begin
            w_peak_upd = r_cur;
            w_hold_upd = {1'b0, r_max_hold};
        end else if (w_hold_diff[HOLD_W]) begin
            // countdown ran out: saturate at -1 and follow the block peak
            w_peak_upd = r_cur;
            w_hold_upd = '1;
        end else begin
            w_peak_upd = r_peak_meter[r_ch];
            w_hold_upd = w_hold_diff[HOLD_W-1:0];
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and handshake outputs
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && w_active) begin
                    n_state = S_SQR;
                end
            end
            S_SQR: begin
                if (r_cnt == SQR_LAST) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = r_last ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (r_cnt == ROOT_LAST) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Settings, meter state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_hold  <= MAX_HOLD_RESET;
            r_active_ch <= ACTIVE_CH_RESET;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_block_peak[i] <= '0;
                r_square_sum[i] <= '0;
                r_block_cnt[i]  <= '0;
                r_rms_meter[i]  <= '0;
                r_peak_meter[i] <= '0;
                r_overall[i]    <= '0;
                r_hold_left[i]  <= '0;
            end
        end else begin
            // configuration write
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_MAX_HOLD:  r_max_hold  <= i_cfg_data;
                    REG_ACTIVE_CH: r_active_ch <= i_cfg_data[ACT_W-1:0];
                    default: ;
                endcase
            end

            // block accumulators: updated per metered sample, cleared at block end
            if (r_state == S_ACC) begin
                if (r_last) begin
                    r_block_peak[r_ch] <= '0;
                    r_square_sum[r_ch] <= '0;
                    r_block_cnt[r_ch]  <= '0;
                end else begin
                    r_block_peak[r_ch] <= w_peak_new;
                    r_square_sum[r_ch] <= w_sum_new;
                    r_block_cnt[r_ch]  <= w_cnt_new;
                end
            end

            // meters and report
            if (r_state == S_UPD && w_out_free) begin
                r_rms_meter[r_ch]  <= w_rms_upd;
                r_peak_meter[r_ch] <= w_peak_upd;
                r_overall[r_ch]    <= w_overall_upd;
                r_hold_left[r_ch]  <= w_hold_upd;
                r_out_valid        <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Serial datapath and output payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_ch      <= i_channel;
                    r_mag     <= w_mag;
                    r_last    <= i_block_end;
                    r_mul_acc <= {{LEVEL_W{1'b0}}, w_mag};
                    r_cnt     <= '0;
                end
            end
            S_SQR: begin
                r_mul_acc <= {w_mul_sum, r_mul_acc[LEVEL_W-1:1]};
                r_cnt     <= r_cnt + STEP_W'(1);
            end
            S_ACC: begin
                r_cur     <= w_peak_new;
                r_n       <= w_cnt_new;
                r_div_num <= w_sum_new;
                r_div_rem <= '0;
                r_decay   <= w_decay_prod[LEVEL_W+DECAY_W-1:DECAY_W];
                r_cnt     <= '0;
            end
            S_DIV: begin
                r_div_num <= w_div_num_nx;
                r_div_rem <= w_div_ge ? w_div_diff[CNT_W-1:0] : w_div_trial[CNT_W-1:0];
                if (r_cnt == DIV_LAST) begin
                    // mean fits in 47 bits; hand it to the root unit
                    r_root_src <= w_div_num_nx[SQR_W-1:0];
                    r_root_rem <= '0;
                    r_root     <= '0;
                    r_cnt      <= '0;
                end else begin
                    r_cnt      <= r_cnt + STEP_W'(1);
                end
            end
            S_ROOT: begin
                r_root_src <= {r_root_src[SQR_W-3:0], 2'b00};
                r_root_rem <= w_root_ge ? w_root_diff[ROOT_REM_W-1:0]
                                        : w_root_t[ROOT_REM_W-1:0];
                r_root     <= {r_root[LEVEL_W-2:0], w_root_ge};
                r_cnt      <= r_cnt + STEP_W'(1);
            end
            S_UPD: begin
                if (w_out_free) begin
                    r_out_ch      <= r_ch;
                    r_out_rms     <= w_rms_upd;
                    r_out_peak    <= w_peak_upd;
                    r_out_overall <= w_overall_upd;
                end
            end
            default: ;
        endcase
    end

    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_report_channel = r_out_ch;
    assign o_rms_level      = r_out_rms;
    assign o_held_peak      = r_out_peak;
    assign o_overall_peak   = r_out_overall;

`ifndef SYNTH
    // held peak never exceeds the overall peak of the same channel
    a_peak_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_held_peak <= o_overall_peak))
        else $error("held peak above overall peak");

    // a metered sample blocks the input until its work is done
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && w_active) |=> !o_in_ready)
        else $error("input ready right after a metered transaction");

    // divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div_rem < r_n))
        else $error("divider remainder out of range");

    // a block end always carries at least one counted sample
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_n != '0))
        else $error("block end with zero sample count");

    // RMS report stays within full scale
    a_rms_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_rms_level <= LEVEL_W'(24'h800000)))
        else $error("RMS level above full scale");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import apm_pkg::*;

    // Run limits
    localparam int unsigned CYCLE_LIMIT       = 2000000;
    localparam int unsigned SETTLE_CYCLES     = 150;
    localparam int unsigned LONG_STALL_CYCLES = 800;
    localparam int unsigned IDLE_MAX          = 11;
    localparam int unsigned FULL_BLOCK_LEN    = 40;

    // Sample extremes and register indexes outside the map
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [CH_W-1:0]            i_channel;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       i_block_end;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic [CH_W-1:0]            o_report_channel;
    logic [LEVEL_W-1:0]         o_rms_level;
    logic [LEVEL_W-1:0]         o_held_peak;
    logic [LEVEL_W-1:0]         o_overall_peak;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_DATA_W-1:0]      i_cfg_data;

    int unsigned send_gap_max = IDLE_MAX;
    int unsigned recv_gap_max = IDLE_MAX;
    bit          long_stall_req = 1'b0;

    typedef struct {
        logic [CH_W-1:0]    ch;
        logic [LEVEL_W-1:0] rms;
        logic [LEVEL_W-1:0] held;
        logic [LEVEL_W-1:0] overall;
    } t_meter_report;

    // Per-channel meter state, settings and the queue of reports still owed
    class meter_tracker;
        t_meter_report        pending_reports[$];
        int unsigned          errors;
        logic [MAXHOLD_W-1:0] hold_limit;
        logic [ACT_W-1:0]     active_count;
        logic [LEVEL_W-1:0]   blk_peak [CHANNELS];
        logic [63:0]          sq_sum   [CHANNELS];
        int unsigned          blk_len  [CHANNELS];
        logic [LEVEL_W-1:0]   rms_lvl  [CHANNELS];
        logic [LEVEL_W-1:0]   held_lvl [CHANNELS];
        logic [LEVEL_W-1:0]   top_lvl  [CHANNELS];
        int                   hold_count [CHANNELS];

        function new();
            errors       = 0;
            hold_limit   = MAX_HOLD_RESET;
            active_count = ACTIVE_CH_RESET;
            foreach (blk_peak[c]) begin
                blk_peak[c]   = '0;
                sq_sum[c]     = '0;
                blk_len[c]    = 0;
                rms_lvl[c]    = '0;
                held_lvl[c]   = '0;
                top_lvl[c]    = '0;
                hold_count[c] = 0;
            end
        endfunction

        function void write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MAX_HOLD:  hold_limit = data[MAXHOLD_W-1:0];
                REG_ACTIVE_CH: active_count = data[ACT_W-1:0];
                default: ;
            endcase
        endfunction

        // Floor of the square root, one result bit per pass
        function logic [LEVEL_W-1:0] int_root(logic [63:0] v);
            logic [63:0] root;
            logic [63:0] trial;
            root = '0;
            for (int b = LEVEL_W; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= v)
                    root = trial;
            end
            return root[LEVEL_W-1:0];
        endfunction

        // Accepted sample transaction: accumulate, and on block end queue a report
        function void take_sample(logic [CH_W-1:0] ch, logic signed [SAMPLE_W-1:0] smp,
                                  logic last);
            logic [SAMPLE_W:0]  wide;
            logic [LEVEL_W-1:0] mag;
            logic [LEVEL_W-1:0] cur;
            logic [LEVEL_W-1:0] root;
            int unsigned        n;
            longint             h;
            t_meter_report      rep;

            if (ch >= active_count)
                return;

            // most negative sample has magnitude 2^23
            wide = smp[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {smp[SAMPLE_W-1], smp})
                                   : {1'b0, smp};
            mag  = wide[LEVEL_W-1:0];

            if (mag > blk_peak[ch])
                blk_peak[ch] = mag;
            // past the block limit only the peak follows
            if (blk_len[ch] < MAX_BLOCK) begin
                sq_sum[ch] += 64'(mag) * 64'(mag);
                blk_len[ch]++;
            end
            if (!last)
                return;

            cur  = blk_peak[ch];
            n    = blk_len[ch];
            root = (n != 0) ? int_root(sq_sum[ch] / n) : '0;

            // RMS rises at once, otherwise decays by 0.9 in Q0.16
            if (root >= rms_lvl[ch])
                rms_lvl[ch] = root;
            else
                rms_lvl[ch] = LEVEL_W'((64'(rms_lvl[ch]) * DECAY_Q16) >> DECAY_W);

            if (cur > top_lvl[ch])
                top_lvl[ch] = cur;

            // peak hold; countdown stops at -1, then the held peak follows
            if (cur >= held_lvl[ch]) begin
                held_lvl[ch]   = cur;
                hold_count[ch] = int'(hold_limit);
            end else begin
                h = longint'(hold_count[ch]) - longint'(n);
                if (h < 0) begin
                    h            = -1;
                    held_lvl[ch] = cur;
                end
                hold_count[ch] = int'(h);
            end

            blk_peak[ch] = '0;
            sq_sum[ch]   = '0;
            blk_len[ch]  = 0;

            rep.ch      = ch;
            rep.rms     = rms_lvl[ch];
            rep.held    = held_lvl[ch];
            rep.overall = top_lvl[ch];
            pending_reports.push_back(rep);
        endfunction

        function void compare_field(string field, logic [LEVEL_W-1:0] want,
                                    logic [LEVEL_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        // Accepted report transaction against the oldest one owed
        function void check_report(logic [CH_W-1:0] ch, logic [LEVEL_W-1:0] rms,
                                   logic [LEVEL_W-1:0] held, logic [LEVEL_W-1:0] overall);
            t_meter_report want;
            if (pending_reports.size() == 0) begin
                errors++;
                $display("%0t: report expected none, got ch %0d rms %0d held %0d overall %0d",
                         $time, ch, rms, held, overall);
                return;
            end
            want = pending_reports.pop_front();
            compare_field("report_channel", LEVEL_W'(want.ch), LEVEL_W'(ch));
            compare_field("rms_level", want.rms, rms);
            compare_field("held_peak", want.held, held);
            compare_field("overall_peak", want.overall, overall);
        endfunction
    endclass

    meter_tracker meter;

    audio_peak_rms_level_meter uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_channel        (i_channel),
        .i_sample         (i_sample),
        .i_block_end      (i_block_end),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_report_channel (o_report_channel),
        .o_rms_level      (o_rms_level),
        .o_held_peak      (o_held_peak),
        .o_overall_peak   (o_overall_peak),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Sample with a spread of magnitudes, extremes now and then
    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        logic signed [SAMPLE_W-1:0] raw;
        raw = SAMPLE_W'($urandom);
        case ($urandom_range(0, 15))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return '0;
            default: return raw >>> $urandom_range(0, SAMPLE_W - 1);
        endcase
    endfunction

    // One sample transaction; valid stays high afterwards unless a gap follows
    task automatic send_sample(input logic [CH_W-1:0] ch,
                               input logic signed [SAMPLE_W-1:0] smp, input logic last);
        int unsigned gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_channel   <= ch;
        i_sample    <= smp;
        i_block_end <= last;
        do @(posedge i_clk); while (!o_in_ready);
        meter.take_sample(ch, smp, last);
    endtask

    // Register write transaction; caller drops valid after the last one
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        meter.write_setting(idx, data);
    endtask

    // Wait for every owed report, then let a trailing block end finish
    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (meter.pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Interleaved channel blocks of random length, some off-range channels mixed in
    task automatic run_random(input int unsigned count);
        int unsigned     metered;
        int unsigned     lanes;
        logic [CH_W-1:0] ch;
        lanes   = (meter.active_count > CHANNELS) ? CHANNELS : meter.active_count;
        metered = 0;
        while (metered < count) begin
            if ($urandom_range(0, 9) == 0)
                ch = CH_W'($urandom_range(0, CHANNELS - 1));
            else
                ch = CH_W'($urandom_range(0, lanes - 1));
            send_sample(ch, random_sample(), $urandom_range(0, 4) == 0);
            if (ch < lanes)
                metered++;
        end
    endtask

    // Report side: random ready gaps, one long hold-off on request
    initial begin : report_sink
        int unsigned gap;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(posedge i_clk);
            end
            gap = $urandom_range(0, recv_gap_max);
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            meter.check_report(o_report_channel, o_rms_level, o_held_peak, o_overall_peak);
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge i_clk);
        $display("tb_top failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned i;
        meter       = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_channel   = '0;
        i_sample    = '0;
        i_block_end = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed samples under the reset settings
        send_sample(3'd0, '0, 1'b1);
        send_sample(3'd0, SAMPLE_MAX, 1'b0);
        send_sample(3'd0, SAMPLE_MIN, 1'b1);
        send_sample(3'd1, 24'sd1, 1'b0);
        send_sample(3'd1, -24'sd1, 1'b1);
        send_sample(3'd2, SAMPLE_MAX, 1'b1);
        send_sample(3'd7, SAMPLE_MIN, 1'b1);
        send_sample(3'd0, 24'sd100, 1'b1);
        send_sample(3'd0, -24'sd200, 1'b0);
        send_sample(3'd0, 24'sd300, 1'b1);
        send_sample(3'd1, SAMPLE_MIN, 1'b1);
        send_sample(3'd1, '0, 1'b1);
        send_sample(3'd1, 24'sd4096, 1'b0);
        send_sample(3'd1, -24'sd4096, 1'b1);
        send_sample(3'd0, SAMPLE_MAX, 1'b1);
        send_sample(3'd0, -SAMPLE_MAX, 1'b1);
        drain_and_settle();

        // No hold, all channels via masked data, writes to unmapped indexes
        cfg_write(REG_MAX_HOLD, '0);
        cfg_write(REG_ACTIVE_CH, 22'h3FFFF8);
        cfg_write(REG_SPARE_A, '1);
        cfg_write(REG_SPARE_B, '1);
        i_cfg_valid <= 1'b0;
        long_stall_req = 1'b1;
        run_random(200);
        drain_and_settle();

        // Longest hold, one channel, no idling on either side
        cfg_write(REG_MAX_HOLD, 22'h3FFFFF);
        cfg_write(REG_ACTIVE_CH, 22'd1);
        i_cfg_valid <= 1'b0;
        send_gap_max = 0;
        recv_gap_max = 0;
        run_random(100);
        drain_and_settle();

        // Zero active channels drops everything
        send_gap_max = IDLE_MAX;
        recv_gap_max = IDLE_MAX;
        cfg_write(REG_MAX_HOLD, 22'd5);
        cfg_write(REG_ACTIVE_CH, 22'd0);
        i_cfg_valid <= 1'b0;
        for (i = 0; i < CHANNELS; i++)
            send_sample(CH_W'(i), random_sample(), i[0]);
        drain_and_settle();

        // Active count above the channel count
        cfg_write(REG_ACTIVE_CH, 22'h3FFFFF);
        i_cfg_valid <= 1'b0;
        run_random(150);
        drain_and_settle();

        // Full scale block on one channel, then mixed traffic
        cfg_write(REG_MAX_HOLD, 22'd37);
        cfg_write(REG_ACTIVE_CH, 22'd5);
        i_cfg_valid <= 1'b0;
        send_gap_max = 0;
        for (i = 0; i < FULL_BLOCK_LEN; i++)
            send_sample(3'd3, SAMPLE_MIN, 1'b0);
        send_sample(3'd3, '0, 1'b1);
        send_gap_max = IDLE_MAX;
        run_random(60);
        drain_and_settle();

        if (meter.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/apm_pkg.sv
sv/audio_peak_rms_level_meter.sv
test/tb_top.sv
